@@ hw/rtl/ftt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_pkg
// Shared types and codes of the five-tuple flow table tracker.
// ----------------------------------------------------------------------------
package ftt_pkg;

    localparam int CNT_W       = 7;
    localparam int QUOT_W      = 16;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 200;
    localparam int CFG_DATA_W  = 16;

    // input opcodes
    localparam logic [2:0] OPC_PACKET   = 3'd0;
    localparam logic [2:0] OPC_CLASSIFY = 3'd1;
    localparam logic [2:0] OPC_BLOCK    = 3'd2;
    localparam logic [2:0] OPC_CLOSE    = 3'd3;
    localparam logic [2:0] OPC_SWEEP    = 3'd4;

    // command classes after decode
    localparam logic [2:0] CL_PKT   = 3'd0;
    localparam logic [2:0] CL_CLS   = 3'd1;
    localparam logic [2:0] CL_BLK   = 3'd2;
    localparam logic [2:0] CL_CLO   = 3'd3;
    localparam logic [2:0] CL_SWEEP = 3'd4;
    localparam logic [2:0] CL_BAD   = 3'd5;

    // stored flow states
    localparam logic [1:0] ST_NEW        = 2'd0;
    localparam logic [1:0] ST_CLASSIFIED = 2'd1;
    localparam logic [1:0] ST_BLOCKED    = 2'd2;
    localparam logic [1:0] ST_CLOSED     = 2'd3;
    localparam logic [2:0] FS_NOT_FOUND  = 3'd4;

    // configuration register indexes
    localparam logic CFG_MAX_FLOWS    = 1'b0;
    localparam logic CFG_IDLE_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [15:0] size;
        logic        outb;
        logic [7:0]  app;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [31:0] ports;
        logic [7:0]  proto;
        logic [1:0]  st;
        logic        drop;
        logic [7:0]  app;
        logic [31:0] pin;
        logic [31:0] pout;
        logic [47:0] bin;
        logic [47:0] bout;
        logic [31:0] tfirst;
        logic [31:0] tlast;
    } t_entry;

    typedef struct packed {
        logic              kind;
        logic              last;
        logic [2:0]        fstate;
        logic              drop;
        logic [CNT_W-1:0]  count;
        logic [31:0]       sip;
        logic [31:0]       dip;
        logic [7:0]        app;
        logic [31:0]       pkts;
        logic [QUOT_W-1:0] avg;
        logic [31:0]       dur;
        logic [31:0]       start;
    } t_res;

endpackage

@@ hw/rtl/ftt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_front
// Accepts items, decodes the opcode into a command class and queues them.
// ----------------------------------------------------------------------------
module ftt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ftt_pkg::t_cmd i_cmd,
    output logic          o_q_valid,
    input  logic          i_q_pop,
    output ftt_pkg::t_cmd o_q_cmd
);

    localparam int Q_DEPTH = 2;

    ftt_pkg::t_cmd r_q [Q_DEPTH];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_fill;
    logic          push;
    logic          pop;
    ftt_pkg::t_cmd dec;

    always_comb begin
        dec = i_cmd;
        unique case (i_cmd.op)
            ftt_pkg::OPC_PACKET:   dec.op = ftt_pkg::CL_PKT;
            ftt_pkg::OPC_CLASSIFY: dec.op = ftt_pkg::CL_CLS;
            ftt_pkg::OPC_BLOCK:    dec.op = ftt_pkg::CL_BLK;
            ftt_pkg::OPC_CLOSE:    dec.op = ftt_pkg::CL_CLO;
            ftt_pkg::OPC_SWEEP:    dec.op = ftt_pkg::CL_SWEEP;
            default:               dec.op = ftt_pkg::CL_BAD;
        endcase
    end

    assign o_ready   = (r_fill != 2'(Q_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_fill != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ hw/rtl/ftt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_div
// Restoring divider for the average size, saturating at sixteen bits.
// ----------------------------------------------------------------------------
module ftt_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [48:0]                i_dividend,
    input  logic [32:0]                i_divisor,
    output logic                       o_done,
    output logic [ftt_pkg::QUOT_W-1:0] o_quot
);

    logic                       r_busy;
    logic                       r_done;
    logic [4:0]                 r_n;
    logic [32:0]                r_rem;
    logic [32:0]                r_dvs;
    logic [15:0]                r_low;
    logic [ftt_pkg::QUOT_W-1:0] r_q;
    logic [33:0]                trial;
    logic                       take;

    assign trial  = {r_rem, r_low[15]};
    assign take   = trial >= {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else if (i_start) begin
            r_dvs <= i_divisor;
            r_n   <= '0;
            if (i_divisor == '0) begin
                r_q    <= '0;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end else if (i_dividend >= {i_divisor, 16'd0}) begin
                r_q    <= '1;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end else begin
                // upper part is already below the divisor
                r_rem  <= i_dividend[48:16];
                r_low  <= i_dividend[15:0];
                r_q    <= '0;
                r_done <= 1'b0;
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= take ? 33'(trial - {1'b0, r_dvs}) : trial[32:0];
            r_low <= {r_low[14:0], 1'b0};
            r_q   <= {r_q[ftt_pkg::QUOT_W-2:0], take};
            r_n   <= r_n + 5'd1;
            if (r_n == 5'(ftt_pkg::QUOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/ftt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_back
// Flow table storage and the sequencer that scans, inserts, updates and removes flows.
// ----------------------------------------------------------------------------
module ftt_back #(
    parameter int FLOWS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_index,
    input  logic [ftt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic                           i_q_valid,
    input  ftt_pkg::t_cmd                  i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output ftt_pkg::t_res                  o_res
);

    localparam int IW = $clog2(FLOWS);
    localparam int CW = $clog2(FLOWS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_UPD_RD  = 4'd2;
    localparam logic [3:0] S_UPD_WR  = 4'd3;
    localparam logic [3:0] S_REC_RD  = 4'd4;
    localparam logic [3:0] S_REC_ST  = 4'd5;
    localparam logic [3:0] S_REC_DIV = 4'd6;
    localparam logic [3:0] S_REC_OUT = 4'd7;
    localparam logic [3:0] S_SW_NEXT = 4'd8;
    localparam logic [3:0] S_NEW_WR  = 4'd9;
    localparam logic [3:0] S_STATUS  = 4'd10;

    localparam logic MODE_EVICT = 1'b0;
    localparam logic MODE_SWEEP = 1'b1;

    ftt_pkg::t_entry mem [FLOWS];
    ftt_pkg::t_entry r_rdata;

    logic [3:0]       r_state, n_state;
    ftt_pkg::t_cmd    r_cmd, n_cmd;
    logic [6:0]       r_maxf;
    logic [15:0]      r_idle;
    logic [FLOWS-1:0] r_valid, n_valid;
    logic [FLOWS-1:0] r_kill, n_kill;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_nkill, n_nkill;
    logic [CW-1:0]    r_left, n_left;
    logic [IW:0]      r_ra, n_ra;
    logic             r_cv, n_cv;
    logic [IW-1:0]    r_ci, n_ci;
    logic             r_hit, n_hit;
    logic [IW-1:0]    r_hidx, n_hidx;
    logic             r_old_v, n_old_v;
    logic [IW-1:0]    r_oidx, n_oidx;
    logic [31:0]      r_otime, n_otime;
    logic             r_free_v, n_free_v;
    logic [IW-1:0]    r_fidx, n_fidx;
    logic [IW-1:0]    r_tidx, n_tidx;
    logic [IW-1:0]    r_ridx, n_ridx;
    logic [IW-1:0]    r_si, n_si;
    logic             r_rmode, n_rmode;
    logic [2:0]       r_sst, n_sst;
    logic             r_sdrop, n_sdrop;
    logic             r_ov, n_ov;
    ftt_pkg::t_res    r_out, n_out;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             we;
    logic [IW-1:0]    wa;
    ftt_pkg::t_entry  wd;

    ftt_pkg::t_entry  e;
    ftt_pkg::t_entry  upd;
    ftt_pkg::t_entry  fresh;
    logic             c_v, c_match, c_kill;
    logic [31:0]      c_age;
    logic             upd_old, upd_free, upd_kill;
    logic             f_hit, f_old_v, f_free_v;
    logic [IW-1:0]    f_hidx, f_oidx, f_fidx;
    logic [CW-1:0]    f_nkill;
    logic             scan_end;
    logic [6:0]       lim;
    logic             full;
    logic             out_free;
    logic [32:0]      pk;
    logic [48:0]      by;
    logic [48:0]      sum_b;
    logic             div_start;
    logic             div_done;
    logic [ftt_pkg::QUOT_W-1:0] div_q;

    ftt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (by),
        .i_divisor  (pk),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_ov;
    assign o_res       = r_out;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign out_free    = !r_ov || i_res_ready;

    assign e  = r_rdata;
    assign pk = {1'b0, e.pin} + {1'b0, e.pout};
    assign by = {1'b0, e.bin} + {1'b0, e.bout};

    // compare stage of the table scan
    always_comb begin
        c_v      = r_valid[r_ci];
        c_match  = (e.sip == r_cmd.sip) && (e.dip == r_cmd.dip) &&
                   (e.ports == {r_cmd.sport, r_cmd.dport}) && (e.proto == r_cmd.proto);
        c_age    = (r_cmd.now >= e.tlast) ? (r_cmd.now - e.tlast) : 32'd0;
        c_kill   = (e.st == ftt_pkg::ST_CLOSED) || (c_age > {16'd0, r_idle});
        upd_old  = r_cv && c_v && (!r_old_v || (e.tlast < r_otime));
        upd_free = r_cv && !c_v && !r_free_v;
        upd_kill = r_cv && c_v && c_kill;
        f_hit    = r_hit || (r_cv && c_v && c_match);
        f_hidx   = r_hit ? r_hidx : r_ci;
        f_old_v  = r_old_v || upd_old;
        f_oidx   = upd_old ? r_ci : r_oidx;
        f_free_v = r_free_v || upd_free;
        f_fidx   = upd_free ? r_ci : r_fidx;
        f_nkill  = r_nkill + CW'(upd_kill);
        scan_end = r_cv && (r_ci == IW'(FLOWS - 1));
        if (r_maxf == 7'd0) begin
            lim = 7'd1;
        end else if (r_maxf > 7'(FLOWS)) begin
            lim = 7'(FLOWS);
        end else begin
            lim = r_maxf;
        end
        full = (7'(r_count) >= lim);
    end

    // entry after a packet, classify, block or close
    always_comb begin
        upd   = e;
        sum_b = '0;
        unique case (r_cmd.op)
            ftt_pkg::CL_PKT: begin
                upd.tlast = r_cmd.now;
                if (r_cmd.outb) begin
                    if (e.pout != '1) begin
                        upd.pout = e.pout + 32'd1;
                    end
                    sum_b    = {1'b0, e.bout} + 49'(r_cmd.size);
                    upd.bout = sum_b[48] ? '1 : sum_b[47:0];
                end else begin
                    if (e.pin != '1) begin
                        upd.pin = e.pin + 32'd1;
                    end
                    sum_b   = {1'b0, e.bin} + 49'(r_cmd.size);
                    upd.bin = sum_b[48] ? '1 : sum_b[47:0];
                end
            end
            ftt_pkg::CL_CLS: begin
                if (e.st != ftt_pkg::ST_CLASSIFIED) begin
                    upd.app = r_cmd.app;
                    upd.st  = ftt_pkg::ST_CLASSIFIED;
                end
            end
            ftt_pkg::CL_BLK: begin
                upd.st   = ftt_pkg::ST_BLOCKED;
                upd.drop = 1'b1;
            end
            ftt_pkg::CL_CLO: begin
                upd.st = ftt_pkg::ST_CLOSED;
            end
            default: begin
                upd = e;
            end
        endcase
    end

    always_comb begin
        fresh.sip    = r_cmd.sip;
        fresh.dip    = r_cmd.dip;
        fresh.ports  = {r_cmd.sport, r_cmd.dport};
        fresh.proto  = r_cmd.proto;
        fresh.st     = ftt_pkg::ST_NEW;
        fresh.drop   = 1'b0;
        fresh.app    = 8'd0;
        fresh.pin    = r_cmd.outb ? 32'd0 : 32'd1;
        fresh.pout   = r_cmd.outb ? 32'd1 : 32'd0;
        fresh.bin    = r_cmd.outb ? 48'd0 : 48'(r_cmd.size);
        fresh.bout   = r_cmd.outb ? 48'(r_cmd.size) : 48'd0;
        fresh.tfirst = r_cmd.now;
        fresh.tlast  = r_cmd.now;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_valid  = r_valid;
        n_kill   = r_kill;
        n_count  = r_count;
        n_nkill  = r_nkill;
        n_left   = r_left;
        n_ra     = r_ra;
        n_cv     = r_cv;
        n_ci     = r_ci;
        n_hit    = r_hit;
        n_hidx   = r_hidx;
        n_old_v  = r_old_v;
        n_oidx   = r_oidx;
        n_otime  = r_otime;
        n_free_v = r_free_v;
        n_fidx   = r_fidx;
        n_tidx   = r_tidx;
        n_ridx   = r_ridx;
        n_si     = r_si;
        n_rmode  = r_rmode;
        n_sst    = r_sst;
        n_sdrop  = r_sdrop;
        n_ov     = r_ov && !i_res_ready;
        n_out    = r_out;
        rd_en    = 1'b0;
        rd_addr  = r_ridx;
        we       = 1'b0;
        wa       = r_tidx;
        wd       = fresh;
        div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cmd = i_q_cmd;
                    if (i_q_cmd.op == ftt_pkg::CL_BAD) begin
                        n_sst   = ftt_pkg::FS_NOT_FOUND;
                        n_sdrop = 1'b0;
                        n_state = S_STATUS;
                    end else begin
                        n_ra     = '0;
                        n_cv     = 1'b0;
                        n_hit    = 1'b0;
                        n_old_v  = 1'b0;
                        n_free_v = 1'b0;
                        n_kill   = '0;
                        n_nkill  = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_en    = (r_ra < (IW + 1)'(FLOWS));
                rd_addr  = r_ra[IW-1:0];
                n_cv     = rd_en;
                n_ci     = r_ra[IW-1:0];
                n_ra     = r_ra + 1'b1;
                n_hit    = f_hit;
                n_hidx   = f_hidx;
                n_old_v  = f_old_v;
                n_oidx   = f_oidx;
                n_free_v = f_free_v;
                n_fidx   = f_fidx;
                n_nkill  = f_nkill;
                if (upd_old) begin
                    n_otime = e.tlast;
                end
                if (upd_kill) begin
                    n_kill[r_ci] = 1'b1;
                end
                if (scan_end) begin
                    n_cv = 1'b0;
                    priority if (r_cmd.op == ftt_pkg::CL_SWEEP) begin
                        if (f_nkill == '0) begin
                            n_sst   = ftt_pkg::FS_NOT_FOUND;
                            n_sdrop = 1'b0;
                            n_state = S_STATUS;
                        end else begin
                            n_count = r_count - f_nkill;
                            n_left  = f_nkill;
                            n_si    = '0;
                            n_rmode = MODE_SWEEP;
                            n_state = S_SW_NEXT;
                        end
                    end else if (f_hit) begin
                        n_state = S_UPD_RD;
                    end else if (r_cmd.op != ftt_pkg::CL_PKT) begin
                        n_sst   = ftt_pkg::FS_NOT_FOUND;
                        n_sdrop = 1'b0;
                        n_state = S_STATUS;
                    end else if (full && f_old_v) begin
                        // the evicted slot or a lower free one takes the new flow
                        n_tidx  = (f_free_v && (f_fidx < f_oidx)) ? f_fidx : f_oidx;
                        n_ridx  = f_oidx;
                        n_rmode = MODE_EVICT;
                        n_state = S_REC_RD;
                    end else begin
                        n_tidx  = f_free_v ? f_fidx : '0;
                        n_count = r_count + CW'(!r_valid[n_tidx]);
                        n_state = S_NEW_WR;
                    end
                end
            end
            S_UPD_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_hidx;
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                we      = 1'b1;
                wa      = r_hidx;
                wd      = upd;
                n_sst   = {1'b0, upd.st};
                n_sdrop = upd.drop;
                n_state = S_STATUS;
            end
            S_NEW_WR: begin
                we               = 1'b1;
                wa               = r_tidx;
                wd               = fresh;
                n_valid[r_tidx]  = 1'b1;
                n_sst            = {1'b0, ftt_pkg::ST_NEW};
                n_sdrop          = 1'b0;
                n_state          = S_STATUS;
            end
            S_REC_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_ridx;
                n_state = S_REC_ST;
            end
            S_REC_ST: begin
                div_start = 1'b1;
                n_state   = S_REC_DIV;
            end
            S_REC_DIV: begin
                if (div_done) begin
                    n_state = S_REC_OUT;
                end
            end
            S_REC_OUT: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_out.kind   = 1'b1;
                    n_out.last   = (r_rmode == MODE_SWEEP) && (r_left == CW'(1));
                    n_out.fstate = {1'b0, e.st};
                    n_out.drop   = e.drop;
                    n_out.count  = ftt_pkg::CNT_W'(r_count);
                    n_out.sip    = e.sip;
                    n_out.dip    = e.dip;
                    n_out.app    = e.app;
                    n_out.pkts   = pk[32] ? '1 : pk[31:0];
                    n_out.avg    = div_q;
                    n_out.dur    = (e.tlast >= e.tfirst) ? (e.tlast - e.tfirst) : 32'd0;
                    n_out.start  = e.tfirst;
                    n_valid[r_ridx] = 1'b0;
                    if (r_rmode == MODE_EVICT) begin
                        n_state = S_NEW_WR;
                    end else if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left  = r_left - 1'b1;
                        n_si    = r_si + 1'b1;
                        n_state = S_SW_NEXT;
                    end
                end
            end
            S_SW_NEXT: begin
                if (r_kill[r_si]) begin
                    n_ridx  = r_si;
                    n_state = S_REC_RD;
                end else begin
                    n_si = r_si + 1'b1;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_out        = '0;
                    n_out.last   = 1'b1;
                    n_out.fstate = r_sst;
                    n_out.drop   = r_sdrop;
                    n_out.count  = ftt_pkg::CNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ra    <= n_ra;
        r_ci    <= n_ci;
        r_hidx  <= n_hidx;
        r_oidx  <= n_oidx;
        r_otime <= n_otime;
        r_fidx  <= n_fidx;
        r_tidx  <= n_tidx;
        r_ridx  <= n_ridx;
        r_si    <= n_si;
        r_rmode <= n_rmode;
        r_sst   <= n_sst;
        r_sdrop <= n_sdrop;
        r_out   <= n_out;
        r_left  <= n_left;
        r_nkill <= n_nkill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_kill   <= '0;
            r_count  <= '0;
            r_cv     <= 1'b0;
            r_hit    <= 1'b0;
            r_old_v  <= 1'b0;
            r_free_v <= 1'b0;
            r_ov     <= 1'b0;
            r_maxf   <= 7'd64;
            r_idle   <= 16'd300;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_kill   <= n_kill;
            r_count  <= n_count;
            r_cv     <= n_cv;
            r_hit    <= n_hit;
            r_old_v  <= n_old_v;
            r_free_v <= n_free_v;
            r_ov     <= n_ov;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ftt_pkg::CFG_MAX_FLOWS:    r_maxf <= i_cfg_data[6:0];
                    ftt_pkg::CFG_IDLE_TIMEOUT: r_idle <= i_cfg_data;
                    default:                   r_idle <= r_idle;
                endcase
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FLOWS))
        else $error("flow count above table size");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_valid) == int'(r_count)))
        else $error("flow count differs from valid entries");

    a_record_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REC_OUT) |-> div_done)
        else $error("record issued before average size is ready");

endmodule

@@ hw/rtl/flow_table_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_table_tracker
// Five-tuple flow table with per-flow counters, eviction and idle sweep.
//
//   channel  dir  handshake              payload
//   s_axis   in   tvalid / tready        tuser opcode, tdata key and packet
//   m_axis   out  tvalid / tready        tuser kind, tlast last, tdata status
//   cfg      in   i_cfg_valid / ready    i_cfg_index, i_cfg_data
//
// packet, classify, block and close items scan the whole table once
// through the single memory read port
// an eviction also emits a record, its average size from the divider
// a sweep scans the table once, then emits a record per removed flow
// a two-item queue and an output register let input and output stall apart
// reset is synchronous; the table starts empty with no clearing pass
// ----------------------------------------------------------------------------
module flow_table_tracker #(
    parameter int FLOWS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // src_ip, dst_ip, src_port, dst_port, ip_protocol, packet_bytes,
    // outbound, app_code, now_seconds
    input  logic [ftt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [2:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // flow_state, drop, active_count, rec_src_ip, rec_dst_ip, rec_app,
    // rec_packets, rec_avg_size, rec_duration, rec_start
    output logic [ftt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [ftt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ftt_pkg::t_cmd in_cmd;
    ftt_pkg::t_cmd q_cmd;
    ftt_pkg::t_res res;
    logic          q_valid;
    logic          q_pop;

    always_comb begin
        in_cmd.op    = s_axis_tuser;
        in_cmd.sip   = s_axis_tdata[31:0];
        in_cmd.dip   = s_axis_tdata[63:32];
        in_cmd.sport = s_axis_tdata[79:64];
        in_cmd.dport = s_axis_tdata[95:80];
        in_cmd.proto = s_axis_tdata[103:96];
        in_cmd.size  = s_axis_tdata[119:104];
        in_cmd.outb  = s_axis_tdata[120];
        in_cmd.app   = s_axis_tdata[128:121];
        in_cmd.now   = s_axis_tdata[160:129];
    end

    ftt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (in_cmd),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_cmd   (q_cmd)
    );

    ftt_back #(
        .FLOWS (FLOWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {5'd0, res.start, res.dur, res.avg, res.pkts, res.app,
                           res.dip, res.sip, res.count, res.drop, res.fstate};

endmodule

@@ tb/flow_table_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_table_tracker_tb
// Self-checking bench for the five-tuple flow table tracker. A local model of
// the table predicts status and removal records for every accepted item, and
// the monitor checks each output item field by field against the oldest
// prediction. The bench runs a directed set, then random phases with several
// table sizes and idle timeouts, with random gaps on both streams.
// ----------------------------------------------------------------------------
module flow_table_tracker_tb;
    import ftt_pkg::*;

    localparam int NFLOWS    = 64;
    localparam int MAX_CYCLE = 1000000;

    typedef struct {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } t_key;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [2:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    flow_table_tracker #(.FLOWS(NFLOWS)) dut (.*);

    // local copy of the table
    logic        tab_valid [NFLOWS];
    t_entry      tab [NFLOWS];
    int unsigned tab_count;
    int unsigned lim_flows;
    int unsigned idle_secs;

    t_cmd   pending_cmds[$];
    t_res   expected_results[$];
    t_cmd   cur_cmd;
    t_key   key_pool[12];
    logic   in_fired;
    int     in_gap;
    int     cfg_taken;
    int     errors;
    int     cycles;
    logic   no_idle;
    logic [31:0] clock_now;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_res flow_record(int i);
        t_res r;
        longint unsigned pk, by, avg;
        r = '0;
        pk = longint'(tab[i].pin) + longint'(tab[i].pout);
        by = longint'(tab[i].bin) + longint'(tab[i].bout);
        avg = 0;
        if (pk != 0) begin
            avg = by / pk;
            if (avg > 65535) avg = 65535;
        end
        r.kind   = 1'b1;
        r.fstate = {1'b0, tab[i].st};
        r.drop   = tab[i].drop;
        r.sip    = tab[i].sip;
        r.dip    = tab[i].dip;
        r.app    = tab[i].app;
        r.pkts   = (pk > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pk[31:0];
        r.avg    = avg[15:0];
        r.dur    = (tab[i].tlast >= tab[i].tfirst) ? tab[i].tlast - tab[i].tfirst : 32'd0;
        r.start  = tab[i].tfirst;
        return r;
    endfunction

    function automatic t_res flow_status(logic [2:0] st, logic drp);
        t_res r;
        r = '0;
        r.fstate = st;
        r.drop   = drp;
        return r;
    endfunction

    function automatic int flow_lookup(t_cmd c);
        for (int k = 0; k < NFLOWS; k++)
            if (tab_valid[k] && tab[k].sip == c.sip && tab[k].dip == c.dip &&
                tab[k].ports == {c.sport, c.dport} && tab[k].proto == c.proto)
                return k;
        return -1;
    endfunction

    function automatic void remove_flow(int i);
        tab_valid[i] = 1'b0;
        if (tab_count > 0) tab_count--;
    endfunction

    // works out the results of one accepted item and updates the table
    function automatic void flow_table_predict(t_cmd c);
        t_res res[$];
        int idx, k, old;
        int unsigned lim;
        longint unsigned age;
        logic [47:0] bmax;
        bmax = '1;
        if (c.op == OPC_PACKET) begin
            lim = lim_flows;
            if (lim < 1) lim = 1;
            if (lim > NFLOWS) lim = NFLOWS;
            idx = flow_lookup(c);
            if (idx < 0) begin
                if (tab_count >= lim) begin
                    old = -1;
                    for (k = 0; k < NFLOWS; k++)
                        if (tab_valid[k] && (old < 0 || tab[k].tlast < tab[old].tlast))
                            old = k;
                    if (old >= 0) begin
                        res.push_back(flow_record(old));
                        remove_flow(old);
                    end
                end
                for (k = 0; k < NFLOWS; k++)
                    if (!tab_valid[k]) break;
                if (k >= NFLOWS) k = 0;
                if (!tab_valid[k]) tab_count++;
                idx = k;
                tab_valid[idx] = 1'b1;
                tab[idx] = '0;
                tab[idx].sip = c.sip;
                tab[idx].dip = c.dip;
                tab[idx].ports = {c.sport, c.dport};
                tab[idx].proto = c.proto;
                tab[idx].st = ST_NEW;
                tab[idx].tfirst = c.now;
            end
            tab[idx].tlast = c.now;
            if (c.outb) begin
                if (tab[idx].pout != 32'hFFFF_FFFF) tab[idx].pout++;
                tab[idx].bout = (bmax - tab[idx].bout < c.size) ? bmax : tab[idx].bout + c.size;
            end else begin
                if (tab[idx].pin != 32'hFFFF_FFFF) tab[idx].pin++;
                tab[idx].bin = (bmax - tab[idx].bin < c.size) ? bmax : tab[idx].bin + c.size;
            end
            res.push_back(flow_status({1'b0, tab[idx].st}, tab[idx].drop));
        end else if (c.op == OPC_CLASSIFY || c.op == OPC_BLOCK || c.op == OPC_CLOSE) begin
            idx = flow_lookup(c);
            if (idx < 0) begin
                res.push_back(flow_status(FS_NOT_FOUND, 1'b0));
            end else begin
                if (c.op == OPC_CLASSIFY) begin
                    if (tab[idx].st != ST_CLASSIFIED) begin
                        tab[idx].app = c.app;
                        tab[idx].st = ST_CLASSIFIED;
                    end
                end else if (c.op == OPC_BLOCK) begin
                    tab[idx].st = ST_BLOCKED;
                    tab[idx].drop = 1'b1;
                end else begin
                    tab[idx].st = ST_CLOSED;
                end
                res.push_back(flow_status({1'b0, tab[idx].st}, tab[idx].drop));
            end
        end else if (c.op == OPC_SWEEP) begin
            for (k = 0; k < NFLOWS; k++) begin
                if (!tab_valid[k]) continue;
                age = (c.now >= tab[k].tlast) ? longint'(c.now - tab[k].tlast) : 0;
                if (age > idle_secs || tab[k].st == ST_CLOSED) begin
                    res.push_back(flow_record(k));
                    remove_flow(k);
                end
            end
            if (res.size() == 0) res.push_back(flow_status(FS_NOT_FOUND, 1'b0));
        end else begin
            res.push_back(flow_status(FS_NOT_FOUND, 1'b0));
        end
        foreach (res[n]) begin
            res[n].last  = (n == res.size() - 1);
            res[n].count = tab_count[CNT_W-1:0];
            expected_results.push_back(res[n]);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // monitor, predictor and config bookkeeping on the rising edge
    always @(posedge i_clk) begin
        t_res exp_r, act_r;
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_FLOWS) lim_flows = i_cfg_data & 16'h7F;
                else idle_secs = i_cfg_data;
                cfg_taken++;
            end
            in_fired = i_rst_n && s_axis_tvalid && s_axis_tready;
            if (in_fired) flow_table_predict(cur_cmd);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                act_r.kind   = m_axis_tuser[0];
                act_r.last   = m_axis_tlast;
                act_r.fstate = m_axis_tdata[2:0];
                act_r.drop   = m_axis_tdata[3];
                act_r.count  = m_axis_tdata[10:4];
                act_r.sip    = m_axis_tdata[42:11];
                act_r.dip    = m_axis_tdata[74:43];
                act_r.app    = m_axis_tdata[82:75];
                act_r.pkts   = m_axis_tdata[114:83];
                act_r.avg    = m_axis_tdata[130:115];
                act_r.dur    = m_axis_tdata[162:131];
                act_r.start  = m_axis_tdata[194:163];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item, actual %0h", $time, act_r);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("kind", exp_r.kind, act_r.kind);
                    check_field("last", exp_r.last, act_r.last);
                    check_field("flow_state", exp_r.fstate, act_r.fstate);
                    check_field("drop", exp_r.drop, act_r.drop);
                    check_field("active_count", exp_r.count, act_r.count);
                    check_field("rec_src_ip", exp_r.sip, act_r.sip);
                    check_field("rec_dst_ip", exp_r.dip, act_r.dip);
                    check_field("rec_app", exp_r.app, act_r.app);
                    check_field("rec_packets", exp_r.pkts, act_r.pkts);
                    check_field("rec_avg_size", exp_r.avg, act_r.avg);
                    check_field("rec_duration", exp_r.dur, act_r.dur);
                    check_field("rec_start", exp_r.start, act_r.start);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // input driver, fed from pending_cmds
    always @(negedge i_clk) begin
        t_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !in_fired)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                c = pending_cmds.pop_front();
                cur_cmd <= c;
                s_axis_tuser <= c.op;
                s_axis_tdata <= {7'd0, c.now, c.app, c.outb, c.size, c.proto,
                                 c.dport, c.sport, c.dip, c.sip};
                s_axis_tvalid <= 1'b1;
                in_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output stalls
    always @(negedge i_clk) begin
        m_axis_tready <= (pick_gap() == 0);
    end

    function automatic t_cmd make_cmd(logic [2:0] op, t_key k);
        t_cmd c;
        c.op = op;
        c.sip = k.sip;
        c.dip = k.dip;
        c.sport = k.sport;
        c.dport = k.dport;
        c.proto = k.proto;
        c.size = $urandom_range(0, 99) < 5 ? 16'hFFFF : 16'($urandom);
        c.outb = $urandom_range(0, 1);
        c.app = 8'($urandom);
        c.now = clock_now;
        return c;
    endfunction

    function automatic t_key rand_key();
        t_key k;
        k.sip = $urandom;
        k.dip = $urandom;
        k.sport = $urandom;
        k.dport = $urandom;
        k.proto = $urandom;
        return k;
    endfunction

    function automatic void push_random(int n, int new_pct);
        t_cmd c;
        int r;
        logic [2:0] op;
        t_key k;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 50) op = OPC_PACKET;
            else if (r < 61) op = OPC_CLASSIFY;
            else if (r < 70) op = OPC_BLOCK;
            else if (r < 79) op = OPC_CLOSE;
            else if (r < 96) op = OPC_SWEEP;
            else op = 3'($urandom_range(5, 7));
            r = $urandom_range(0, 99);
            if (r < 88) clock_now = clock_now + $urandom_range(0, 40);
            else if (r < 97) clock_now = clock_now + $urandom_range(200, 70000);
            else clock_now = clock_now - $urandom_range(1, 500);
            k = ($urandom_range(0, 99) < new_pct) ? rand_key() : key_pool[$urandom_range(0, 11)];
            c = make_cmd(op, k);
            pending_cmds.push_back(c);
        end
    endfunction

    task automatic cfg_write(logic idx, logic [CFG_DATA_W-1:0] val);
        int seen;
        seen = cfg_taken;
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(negedge i_clk); while (cfg_taken == seen);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] mf, logic [CFG_DATA_W-1:0] to,
                             int n, int new_pct);
        cfg_write(CFG_MAX_FLOWS, mf);
        cfg_write(CFG_IDLE_TIMEOUT, to);
        no_idle = ($urandom_range(0, 3) == 0);
        push_random(n, new_pct);
        wait_drained();
    endtask

    initial begin
        t_cmd c;
        t_key ka, kb, kz;
        errors = 0;
        cycles = 0;
        cfg_taken = 0;
        in_fired = 1'b0;
        in_gap = 0;
        no_idle = 1'b0;
        lim_flows = 64;
        idle_secs = 300;
        tab_count = 0;
        foreach (tab_valid[k]) tab_valid[k] = 1'b0;
        foreach (key_pool[k]) key_pool[k] = rand_key();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cur_cmd = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX_FLOWS;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every operation, unknown flows and bad opcodes
        ka = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF};
        kb = key_pool[0];
        kz = '{32'd0, 32'd0, 16'd0, 16'd0, 8'd0};
        clock_now = 32'd0;
        c = make_cmd(OPC_SWEEP, kz);       pending_cmds.push_back(c);
        c = make_cmd(OPC_CLASSIFY, ka);    pending_cmds.push_back(c);
        c = make_cmd(OPC_PACKET, kz); c.size = 0; c.outb = 0; pending_cmds.push_back(c);
        c = make_cmd(OPC_PACKET, ka); c.size = 16'hFFFF; c.outb = 1; pending_cmds.push_back(c);
        c = make_cmd(OPC_PACKET, ka); c.size = 16'hFFFF; c.outb = 0; pending_cmds.push_back(c);
        c = make_cmd(OPC_CLASSIFY, ka); c.app = 8'hFF; pending_cmds.push_back(c);
        c = make_cmd(OPC_CLASSIFY, ka); c.app = 8'h00; pending_cmds.push_back(c);
        c = make_cmd(OPC_BLOCK, ka);       pending_cmds.push_back(c);
        c = make_cmd(OPC_PACKET, ka);      pending_cmds.push_back(c);
        c = make_cmd(OPC_CLASSIFY, ka); c.app = 8'h5A; pending_cmds.push_back(c);
        c = make_cmd(OPC_BLOCK, kb);       pending_cmds.push_back(c);
        c = make_cmd(OPC_CLOSE, kb);       pending_cmds.push_back(c);
        c = make_cmd(OPC_PACKET, kb); c.now = 32'hFFFF_FFFF; pending_cmds.push_back(c);
        c = make_cmd(OPC_CLOSE, kz);       pending_cmds.push_back(c);
        // closed flow goes on sweep; kb's last-seen is in the future so it stays
        c = make_cmd(OPC_SWEEP, kz); c.now = 32'd10; pending_cmds.push_back(c);
        c = make_cmd(3'd5, ka);            pending_cmds.push_back(c);
        c = make_cmd(3'd6, ka);            pending_cmds.push_back(c);
        c = make_cmd(3'd7, ka);            pending_cmds.push_back(c);
        wait_drained();

        // eviction with a tiny table, the flow with the oldest last-seen goes first
        cfg_write(CFG_MAX_FLOWS, 16'd2);
        clock_now = 32'd500;
        c = make_cmd(OPC_PACKET, key_pool[1]); pending_cmds.push_back(c);
        c = make_cmd(OPC_PACKET, key_pool[2]); pending_cmds.push_back(c);
        c = make_cmd(OPC_PACKET, key_pool[3]); pending_cmds.push_back(c);
        c = make_cmd(OPC_SWEEP, kz); c.now = 32'hFFFF_FFFF; pending_cmds.push_back(c);
        wait_drained();

        clock_now = 32'd1000;
        run_phase(16'd64, 16'd300, 60, 15);
        run_phase(16'd4, 16'd50, 60, 20);
        run_phase(16'd1, 16'd0, 30, 20);
        run_phase(16'd0, 16'hFFFF, 30, 20);
        run_phase(16'hFFFF, 16'd300, 30, 20);
        // fill the whole table, then evict at full size and sweep it empty
        run_phase(16'd64, 16'hFFFF, 90, 90);
        run_phase(16'd64, 16'd0, 10, 5);
        run_phase(16'd64, 16'd300, 50, 10);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
